@@ design/phrf_pkg.sv @@
// Shared types and constants for the printer reply handshake filter.
`timescale 1ns / 1ps

package phrf_pkg;

  localparam int unsigned MaxBeats = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [7:0] ByteAck = 8'h06;
  localparam logic [7:0] ByteMark = 8'hFF;
  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteNul = 8'h00;
  localparam logic [7:0] LetterS = 8'h53;
  localparam logic [7:0] LetterF = 8'h46;
  localparam logic [7:0] LetterU = 8'h55;

  localparam logic CfgIdxEnqAck = 1'b0;
  localparam logic CfgIdxParmrk = 1'b1;

  typedef enum logic [2:0] {
    EvKey   = 3'd0,
    EvEnq   = 3'd1,
    EvData  = 3'd2,
    EvOk    = 3'd3,
    EvFail  = 3'd4,
    EvBreak = 3'd5
  } event_e;

  typedef struct packed {
    logic [1:0]                  cnt;
    event_e [MaxBeats-1:0]       ev;
    logic [MaxBeats-1:0][7:0]    key;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ design/phrf_front.sv @@
// Front part: accepts items, tracks the handshake state and builds result bundles.
`timescale 1ns / 1ps

module phrf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              kind_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              enq_ack_mode_i,
  input  logic              parmrk_mode_i,
  output logic              bundle_valid_o,
  output phrf_pkg::bundle_t bundle_o
);
  import phrf_pkg::*;

  typedef enum logic [1:0] {
    PhIdle      = 2'd0,
    PhWaitAck   = 2'd1,
    PhWaitReply = 2'd2,
    PhSpare     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EscNone  = 2'd0,
    EscMark  = 2'd1,
    EscMark0 = 2'd2,
    EscSpare = 2'd3
  } esc_e;

  phase_e     phase_q, phase_d;
  esc_e       esc_q, esc_d;
  logic [7:0] pend_q, pend_d;

  logic [1:0] n;
  bundle_t    b;
  logic       done;
  logic       active;
  logic       c_letter;
  logic       p_letter;

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    pend_d   = pend_q;
    b        = '0;
    n        = 2'd0;
    done     = 1'b0;
    active   = (phase_q == PhWaitAck) || (phase_q == PhWaitReply);
    c_letter = (rx_byte_i == LetterS) || (rx_byte_i == LetterF) || (rx_byte_i == LetterU);
    p_letter = (pend_q == LetterS) || (pend_q == LetterF) || (pend_q == LetterU);

    if (!kind_i) begin
      esc_d  = EscNone;
      pend_d = '0;
      if (enq_ack_mode_i) begin
        phase_d = PhWaitAck;
        b.ev[0] = EvEnq;
      end else begin
        phase_d = PhWaitReply;
        b.ev[0] = EvData;
      end
      n = 2'd1;
    end else if (!active) begin
      b.ev[0]  = EvKey;
      b.key[0] = rx_byte_i;
      n = 2'd1;
    end else if (esc_q == EscMark) begin
      if (rx_byte_i != ByteNul) begin
        b.ev[0]  = EvKey;
        b.key[0] = ByteMark;
        b.ev[1]  = EvKey;
        b.key[1] = rx_byte_i;
        n = 2'd2;
        esc_d = EscNone;
      end else begin
        esc_d = EscMark0;
      end
    end else if (esc_q != EscNone) begin
      if (rx_byte_i != ByteNul) begin
        b.ev[0]  = EvKey;
        b.key[0] = ByteMark;
        b.ev[1]  = EvKey;
        b.key[1] = ByteNul;
        b.ev[2]  = EvKey;
        b.key[2] = rx_byte_i;
        n = 2'd3;
        esc_d = EscNone;
      end else begin
        phase_d = PhIdle;
        esc_d   = EscNone;
        pend_d  = '0;
        b.ev[0] = EvBreak;
        n = 2'd1;
      end
    end else begin
      if (phase_q == PhWaitAck) begin
        if (rx_byte_i == ByteAck) begin
          phase_d = PhWaitReply;
          pend_d  = '0;
          b.ev[0] = EvData;
          n = 2'd1;
          done = 1'b1;
        end
      end else if (pend_q != '0) begin
        if (rx_byte_i == ByteCr && p_letter) begin
          phase_d = PhIdle;
          esc_d   = EscNone;
          pend_d  = '0;
          b.ev[0] = (pend_q == LetterS) ? EvOk : EvFail;
          n = 2'd1;
          done = 1'b1;
        end else begin
          b.ev[0]  = EvKey;
          b.key[0] = pend_q;
          n = 2'd1;
          pend_d = '0;
        end
      end

      if (!done) begin
        if (phase_q == PhWaitReply && c_letter) begin
          pend_d = rx_byte_i;
        end else if (rx_byte_i == ByteNul && !parmrk_mode_i) begin
          phase_d = PhIdle;
          esc_d   = EscNone;
          pend_d  = '0;
          b.ev[n] = EvBreak;
          n = n + 2'd1;
        end else if (rx_byte_i == ByteMark && parmrk_mode_i) begin
          esc_d = EscMark;
        end else begin
          b.ev[n]  = EvKey;
          b.key[n] = rx_byte_i;
          n = n + 2'd1;
        end
      end
    end

    b.cnt = n;
  end

  assign bundle_o       = b;
  assign bundle_valid_o = accept_i && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      esc_q   <= EscNone;
      pend_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      pend_q  <= pend_d;
    end
  end

endmodule

@@ design/phrf_queue.sv @@
// Short queue of result bundles between the front and back parts.
`timescale 1ns / 1ps

module phrf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  phrf_pkg::bundle_t   wr_data_i,
  input  logic                rd_i,
  output phrf_pkg::bundle_t   rd_data_o,
  output phrf_pkg::q_status_t status_o
);
  import phrf_pkg::*;

  bundle_t             mem_q [QDepth];
  logic [QAddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]    cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign do_wr = wr_i && !status_o.full;
  assign do_rd = rd_i && !status_o.empty;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QAddrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QAddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/phrf_back.sv @@
// Back part: steps through the beats of the bundle at the head of the queue.
`timescale 1ns / 1ps

module phrf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phrf_pkg::bundle_t   head_i,
  input  phrf_pkg::q_status_t q_status_i,
  input  logic                pop_i,
  output logic                q_rd_o,
  output logic [2:0]          event_res_o,
  output logic [7:0]          key_byte_o,
  output logic                last_o
);
  import phrf_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       take;

  assign event_res_o = 3'(head_i.ev[idx_q]);
  assign key_byte_o  = head_i.key[idx_q];
  assign last_o      = (idx_q == head_i.cnt - 2'd1);
  assign take        = pop_i && !q_status_i.empty;
  assign q_rd_o      = take && last_o;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ design/printer_reply_handshake_filter_core.sv @@
// Top level of the printer reply handshake filter.
`timescale 1ns / 1ps

// Filters terminal receive bytes during a transparent print. Items enter through a
// queue-like port (push/full) and may arrive in every cycle while full is low; the
// front part updates the handshake state in the cycle of acceptance and files the
// one to three results of an item as one bundle in a four-entry queue, filing none
// for an item with no results. The back part hands out one result beat per cycle
// (empty/pop) while pop is high and empty is low, with last_o set on the final beat
// of each item, and frees the bundle on that beat. Configuration writes are registered.
module printer_reply_handshake_filter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_res_o,
  output logic [7:0] key_byte_o,
  output logic       last_o
);
  import phrf_pkg::*;

  logic      enq_ack_mode_q;
  logic      parmrk_mode_q;
  logic      accept;
  logic      bundle_valid;
  bundle_t   bundle;
  bundle_t   head;
  q_status_t q_status;
  logic      q_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enq_ack_mode_q <= 1'b0;
      parmrk_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxEnqAck: enq_ack_mode_q <= cfg_data_i;
        CfgIdxParmrk: parmrk_mode_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full   = q_status.full;
  assign empty  = q_status.empty;
  assign accept = push && !full;

  phrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .kind_i         (kind_i),
    .rx_byte_i      (rx_byte_i),
    .enq_ack_mode_i (enq_ack_mode_q),
    .parmrk_mode_i  (parmrk_mode_q),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  phrf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (bundle_valid),
    .wr_data_i (bundle),
    .rd_i      (q_rd),
    .rd_data_o (head),
    .status_o  (q_status)
  );

  phrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_i       (pop),
    .q_rd_o      (q_rd),
    .event_res_o (event_res_o),
    .key_byte_o  (key_byte_o),
    .last_o      (last_o)
  );

`ifndef SYNTH
  a_start_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !kind_i) |-> bundle_valid)
    else $error("Start item produced no result bundle.");

  a_more_beats_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) |=> !empty)
    else $error("Queue emptied before the last beat of an item.");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (head.cnt != 2'd0))
    else $error("Queued bundle holds no beats.");
`endif

endmodule

@@ dv/tb_printer_reply_handshake_filter_core.sv @@
// Self-checking testbench for the printer reply handshake filter core.
`timescale 1ns / 1ps

module tb_printer_reply_handshake_filter_core;
  import phrf_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxGap = 14;
  localparam int unsigned RandomItems = 460;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned ReportLimit = 10;

  localparam logic KindStart = 1'b0;
  localparam logic KindByte = 1'b1;

  typedef enum logic [1:0] {
    PhIdle      = 2'd0,
    PhWaitAck   = 2'd1,
    PhWaitReply = 2'd2
  } phase_e;

  typedef struct packed {
    event_e     ev;
    logic [7:0] key;
    logic       last;
  } beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic       cfg_data_i;
  logic       push;
  logic       full;
  logic       kind_i;
  logic [7:0] rx_byte_i;
  logic       empty;
  logic       pop;
  logic [2:0] event_res_o;
  logic [7:0] key_byte_o;
  logic       last_o;

  printer_reply_handshake_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .rx_byte_i   (rx_byte_i),
    .empty       (empty),
    .pop         (pop),
    .event_res_o (event_res_o),
    .key_byte_o  (key_byte_o),
    .last_o      (last_o)
  );

  beat_t       expected_beats[$];
  phase_e      print_phase;
  logic [1:0]  escape_stage;
  logic [7:0]  held_letter;
  logic        enq_ack_mode;
  logic        parmrk_mode;
  int unsigned item_beats;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          tx_quiet;
  bit          rx_quiet;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL printer_reply_handshake_filter_core");
      $finish;
    end
  end

  function automatic bit is_reply_letter(logic [7:0] c);
    return c == LetterS || c == LetterF || c == LetterU;
  endfunction

  function automatic void add_beat(event_e ev, logic [7:0] key);
    beat_t b;
    b.ev = ev;
    b.key = key;
    b.last = 1'b0;
    expected_beats.push_back(b);
    item_beats++;
  endfunction

  function automatic void close_print();
    print_phase = PhIdle;
    escape_stage = 2'd0;
    held_letter = ByteNul;
  endfunction

  function automatic void predict_filter_beats(logic k, logic [7:0] c);
    bit done;
    done = 1'b0;
    item_beats = 0;
    if (k == KindStart) begin
      escape_stage = 2'd0;
      held_letter = ByteNul;
      if (enq_ack_mode) begin
        print_phase = PhWaitAck;
        add_beat(EvEnq, 8'h00);
      end else begin
        print_phase = PhWaitReply;
        add_beat(EvData, 8'h00);
      end
    end else if (print_phase != PhWaitAck && print_phase != PhWaitReply) begin
      add_beat(EvKey, c);
    end else if (escape_stage == 2'd1) begin
      if (c != ByteNul) begin
        add_beat(EvKey, ByteMark);
        add_beat(EvKey, c);
        escape_stage = 2'd0;
      end else begin
        escape_stage = 2'd2;
      end
    end else if (escape_stage != 2'd0) begin
      if (c != ByteNul) begin
        add_beat(EvKey, ByteMark);
        add_beat(EvKey, ByteNul);
        add_beat(EvKey, c);
        escape_stage = 2'd0;
      end else begin
        close_print();
        add_beat(EvBreak, 8'h00);
      end
    end else begin
      if (print_phase == PhWaitAck) begin
        if (c == ByteAck) begin
          print_phase = PhWaitReply;
          held_letter = ByteNul;
          add_beat(EvData, 8'h00);
          done = 1'b1;
        end
      end else if (held_letter != ByteNul) begin
        if (c == ByteCr && is_reply_letter(held_letter)) begin
          add_beat((held_letter == LetterS) ? EvOk : EvFail, 8'h00);
          close_print();
          done = 1'b1;
        end else begin
          add_beat(EvKey, held_letter);
          held_letter = ByteNul;
        end
      end
      if (!done) begin
        if (print_phase == PhWaitReply && is_reply_letter(c)) begin
          held_letter = c;
        end else if (c == ByteNul && !parmrk_mode) begin
          close_print();
          add_beat(EvBreak, 8'h00);
        end else if (c == ByteMark && parmrk_mode) begin
          escape_stage = 2'd1;
        end else begin
          add_beat(EvKey, c);
        end
      end
    end
    if (item_beats > 0) expected_beats[expected_beats.size()-1].last = 1'b1;
  endfunction

  task automatic check_beat();
    beat_t got;
    beat_t want;
    got.ev = event_e'(event_res_o);
    got.key = key_byte_o;
    got.last = last_o;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("unexpected beat: ev=%0d key=%h last=%b", got.ev, got.key, got.last);
    end else begin
      want = expected_beats.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("mismatch: expected ev=%0d key=%h last=%b, got ev=%0d key=%h last=%b",
                   want.ev, want.key, want.last, got.ev, got.key, got.last);
      end
    end
  endtask

  initial begin
    int unsigned gap;
    pop = 1'b0;
    rx_quiet = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      @(negedge clk_i);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_beat();
      if ($urandom_range(0, 15) == 0) rx_quiet = ~rx_quiet;
    end
  end

  task automatic send_item(input logic k, input logic [7:0] c);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    kind_i <= k;
    rx_byte_i <= c;
    do @(posedge clk_i); while (full);
    predict_filter_beats(k, c);
    items_sent++;
  endtask

  task automatic send_rx(input logic [7:0] c);
    send_item(KindByte, c);
  endtask

  task automatic send_start();
    send_item(KindStart, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_replies();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CfgIdxEnqAck) enq_ack_mode = val;
    else parmrk_mode = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_modes(input logic enq, input logic pm);
    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CfgIdxEnqAck, enq);
    write_reg(CfgIdxParmrk, pm);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return ByteNul;
      1: return ByteMark;
      2: return ByteAck;
      3: return ByteCr;
      4: return LetterS;
      5: return LetterF;
      6: return LetterU;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_break();
    if (parmrk_mode) begin
      send_rx(ByteMark);
      send_rx(ByteNul);
      send_rx(ByteNul);
    end else begin
      send_rx(ByteNul);
    end
  endtask

  task automatic run_transaction();
    send_start();
    if (enq_ack_mode) begin
      repeat ($urandom_range(0, 2)) send_rx(pick_byte());
      if ($urandom_range(0, 7) != 0) send_rx(ByteAck);
    end
    repeat ($urandom_range(0, 3)) send_rx(pick_byte());
    case ($urandom_range(0, 5))
      0: begin send_rx(LetterS); send_rx(ByteCr); end
      1: begin send_rx(LetterF); send_rx(ByteCr); end
      2: begin send_rx(LetterU); send_rx(ByteCr); end
      3: send_break();
      4: begin
        send_rx(ByteMark);
        if ($urandom_range(0, 1) == 0) send_rx(ByteNul);
        send_rx(pick_byte());
      end
      default: ;
    endcase
  endtask

  task automatic test_idle_bytes();
    set_modes(1'b0, 1'b0);
    send_rx(ByteNul);
    send_rx(ByteMark);
    send_rx(ByteAck);
  endtask

  task automatic test_direct_print();
    send_start();
    send_rx(LetterS);
    send_rx(ByteCr);
    send_start();
    send_rx(LetterU);
    send_rx(8'h41);
    send_rx(LetterF);
    send_rx(ByteNul);
    send_start();
    send_rx(LetterS);
    send_start();
    send_rx(LetterF);
    send_rx(ByteCr);
  endtask

  task automatic test_enq_ack_parmrk();
    set_modes(1'b1, 1'b1);
    tx_quiet = 1'b1;
    send_start();
    send_rx(LetterS);
    send_rx(ByteMark);
    send_rx(ByteAck);
    send_rx(ByteAck);
    send_rx(LetterF);
    send_rx(ByteMark);
    send_rx(ByteNul);
    send_rx(8'h42);
    send_rx(ByteMark);
    send_rx(ByteNul);
    send_rx(ByteNul);
    tx_quiet = 1'b0;
  endtask

  task automatic test_mode_change_mid_escape();
    send_start();
    send_rx(ByteMark);
    set_modes(1'b1, 1'b0);
    send_rx(ByteNul);
    send_rx(ByteNul);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    logic enq;
    logic pm;
    for (int p = 0; p < RandomPhases; p++) begin
      enq = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      pm = (p < 4) ? p[1] : 1'($urandom_range(0, 1));
      set_modes(enq, pm);
      target = items_sent + RandomItems / RandomPhases;
      while (items_sent < target) begin
        tx_quiet = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(0, 1)), pick_byte());
        end else begin
          run_transaction();
        end
        if ($urandom_range(0, 39) == 0) wait_for_replies();
      end
    end
    tx_quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgIdxEnqAck;
    cfg_data_i = 1'b0;
    push = 1'b0;
    kind_i = KindStart;
    rx_byte_i = 8'h00;
    tx_quiet = 1'b0;
    enq_ack_mode = 1'b0;
    parmrk_mode = 1'b0;
    close_print();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_bytes();
    test_direct_print();
    test_enq_ack_parmrk();
    test_mode_change_mid_escape();
    test_random_traffic();

    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS printer_reply_handshake_filter_core");
    end else begin
      $display("FAIL printer_reply_handshake_filter_core");
    end
    $finish;
  end

endmodule
